[hw/rtl/lzwc_pkg.sv]
package lzwc_pkg;

    localparam int MAX_CODES_DEF   = 4096;
    localparam int FIRST_WIDTH     = 9;
    localparam int FIRST_FREE_CODE = 257;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  code_width;
        logic        last_code;
    } out_word_t;

endpackage

[hw/rtl/lzwc_ram.sv]
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/lzw_byte_compressor.sv]
// LZW byte compressor, variable code width, dictionary cleared when full.
// A byte after the root is handled on accept alone; any other byte also passes hash-map read,
// dictionary read, and compare and update; a last byte adds the final prefix and the end code.
// A byte is taken only when idle with at most one word queued; codes enter on a miss and at flush.
// Reset (aresetn, synchronous, active low) empties the output queue and returns
// prefix, next code and width to their start values; memories are not cleared.
module lzw_byte_compressor #(
    parameter int MAX_CODES = lzwc_pkg::MAX_CODES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzwc_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output lzwc_pkg::out_word_t m_word
);
    import lzwc_pkg::*;

    // Code, key and width sizes follow from the dictionary depth.
    localparam int CW     = $clog2(MAX_CODES);
    localparam int KW     = CW + 8;
    localparam int HDEPTH = 1 << KW;
    localparam int WW     = $clog2(CW + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_TERM  = 3'd4;

    localparam logic [CW:0]   NC_RESET = (CW+1)'(FIRST_FREE_CODE);
    localparam logic [CW:0]   NC_LIMIT = (CW+1)'(MAX_CODES);
    localparam logic [WW-1:0] W_RESET  = WW'(FIRST_WIDTH);

    logic [2:0]    state_reg, state_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic [CW-1:0] prefix_reg, prefix_next;
    logic [CW:0]   next_code_reg, next_code_next;
    logic [WW-1:0] width_reg, width_next;
    logic [CW-1:0] cand_reg, cand_next;

    // Output queue: four words, one push per cycle.
    out_word_t     fifo_reg [4];
    logic [1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [2:0]    count_reg;
    logic          push;
    out_word_t     push_word;
    logic          pop;

    // Hash map: key -> code; dictionary: code -> key (validates the map entry).
    logic          hmap_wr_en, hmap_rd_en;
    logic [KW-1:0] hmap_rd_addr;
    logic [CW-1:0] hmap_rd_data;
    logic          dict_wr_en, dict_rd_en;
    logic [KW-1:0] dict_rd_data;

    logic [KW-1:0] key_now;
    logic          hit;
    logic          accept;
    logic [CW:0]   nc_inc;

    lzwc_ram #(.WIDTH(CW), .DEPTH(HDEPTH)) u_hmap (
        .aclk    (aclk),
        .wr_en   (hmap_wr_en),
        .wr_addr (key_now),
        .wr_data (next_code_reg[CW-1:0]),
        .rd_en   (hmap_rd_en),
        .rd_addr (hmap_rd_addr),
        .rd_data (hmap_rd_data)
    );

    lzwc_ram #(.WIDTH(KW), .DEPTH(MAX_CODES)) u_dict (
        .aclk    (aclk),
        .wr_en   (dict_wr_en),
        .wr_addr (next_code_reg[CW-1:0]),
        .wr_data (key_now),
        .rd_en   (dict_rd_en),
        .rd_addr (hmap_rd_data),
        .rd_data (dict_rd_data)
    );

    assign s_ready = (state_reg == S_IDLE) && (count_reg <= 3'd1);
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != 3'd0);
    assign m_word  = fifo_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    assign key_now = {prefix_reg, byte_reg};
    assign nc_inc  = next_code_reg + 1'b1;

    // A map entry counts only if it names a live code whose stored key matches.
    assign hit = (cand_reg >= CW'(FIRST_FREE_CODE))
              && ({1'b0, cand_reg} < next_code_reg)
              && (dict_rd_data == key_now);

    assign hmap_rd_en   = accept;
    assign hmap_rd_addr = {prefix_reg, s_word.data_byte};
    assign dict_rd_en   = (state_reg == S_LOOK);

    always_comb begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        prefix_next    = prefix_reg;
        next_code_next = next_code_reg;
        width_next     = width_reg;
        cand_next      = cand_reg;
        push           = 1'b0;
        push_word      = '{code: 12'(prefix_reg), code_width: 4'(width_reg), last_code: 1'b0};
        hmap_wr_en     = 1'b0;
        dict_wr_en     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    byte_next = s_word.data_byte;
                    last_next = s_word.end_of_stream;
                    if (prefix_reg == '0) begin
                        // Root: a single byte always hits its own code.
                        prefix_next = CW'({1'b0, s_word.data_byte} + 9'd1);
                        state_next  = s_word.end_of_stream ? S_FLUSH : S_IDLE;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                cand_next  = hmap_rd_data;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (hit) begin
                    prefix_next = cand_reg;
                end else begin
                    // Miss: emit the prefix, learn the new phrase, restart from the byte.
                    push        = 1'b1;
                    hmap_wr_en  = 1'b1;
                    dict_wr_en  = 1'b1;
                    prefix_next = CW'({1'b0, byte_reg} + 9'd1);
                    if (nc_inc >= NC_LIMIT) begin
                        next_code_next = NC_RESET;
                        width_next     = W_RESET;
                    end else begin
                        next_code_next = nc_inc;
                        if ((nc_inc & (nc_inc - 1'b1)) == '0) begin
                            width_next = width_reg + 1'b1;
                        end
                    end
                end
                state_next = last_reg ? S_FLUSH : S_IDLE;
            end
            S_FLUSH: begin
                push       = 1'b1;
                state_next = S_TERM;
            end
            S_TERM: begin
                push           = 1'b1;
                push_word      = '{code: 12'd0, code_width: 4'(width_reg), last_code: 1'b1};
                prefix_next    = '0;
                next_code_next = NC_RESET;
                width_next     = W_RESET;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prefix_reg    <= '0;
            next_code_reg <= NC_RESET;
            width_reg     <= W_RESET;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            next_code_reg <= next_code_next;
            width_reg     <= width_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        cand_reg <= cand_next;
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_word;
        end
    end

    // The queue never overflows: an item enters only with room for three words.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("output queue overflow");

    // Live codes stay in range between the first free code and the limit.
    a_next_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_code_reg >= NC_RESET) && (next_code_reg < NC_LIMIT))
        else $error("next code out of range");

    // The current phrase always names a code that exists.
    a_prefix_live: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, prefix_reg} < next_code_reg)
        else $error("prefix names an unassigned code");

    // The end code follows the flushed prefix directly.
    a_term_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH) |=> (state_reg == S_TERM) && push)
        else $error("end code did not follow final prefix");

endmodule
